// ===== rtl/keyed_slot_table_defines.svh =====
// Assertion macros for the keyed slot table.
`ifndef KEYED_SLOT_TABLE_DEFINES_SVH
`define KEYED_SLOT_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KST_ASSERT(lbl, prop, msg)
`define KST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/kst_pkg.sv =====
// Types and constants shared by the keyed slot table.
package kst_pkg;

  localparam int unsigned MaxEntriesDef = 8;
  localparam int unsigned KeyW          = 8;
  localparam int unsigned SizeW         = 32;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic             hidden;
    logic [SizeW-1:0] size;
  } rec_t;

  typedef struct packed {
    logic en;
    rec_t data;
  } wr_req_t;

endpackage

// ===== rtl/kst_ram.sv =====
// Record memory: one write port, one read port with registered data.
module kst_ram #(
  parameter int unsigned DEPTH = kst_pkg::MaxEntriesDef,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output kst_pkg::rec_t    rd_data_o,
  input  kst_pkg::wr_req_t wr_i,
  input  logic [IDX_W-1:0] wr_addr_i
);
  import kst_pkg::*;

  rec_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== rtl/keyed_slot_table.sv =====
// Keyed slot table top level: request decode, record scan and result.
//
// A request (func_i, slot_key_i, hidden_flag_i, image_bytes_i) is taken at a
// rising edge where start is high and busy is low. The block then scans all
// MAX_ENTRIES records through the single read port of the record memory, one
// record per cycle, and then commits the set, remove or find in the DONE state.
// The result (status_o, found_hidden_o, found_image_bytes_o, entry_count_o)
// is shown for exactly one cycle with done_o high, registered from the DONE
// state. busy is high from the accepting edge until the result cycle, so a new
// request can be taken in the cycle done_o is high; no request is taken while
// the scan of the memory read port or the commit is in progress. The receiver
// cannot stall; each result must be taken in its cycle.
// Reset clears all valid bits and the entry count at once; the record memory
// needs no clearing, since only valid records are ever compared or returned.
module keyed_slot_table #(
  parameter int unsigned MAX_ENTRIES = kst_pkg::MaxEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func_i,
  input  logic [kst_pkg::KeyW-1:0]  slot_key_i,
  input  logic                      hidden_flag_i,
  input  logic [kst_pkg::SizeW-1:0] image_bytes_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic                      found_hidden_o,
  output logic [kst_pkg::SizeW-1:0] found_image_bytes_o,
  output logic [3:0]                entry_count_o
);
  import kst_pkg::*;

  `include "keyed_slot_table_defines.svh"

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_ENTRIES);

  fsm_e                   state_q, state_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       rd_idx_q, chk_idx_q, hit_idx_q, free_idx_q;
  logic                   rd_end_q, chk_vld_q, hit_q, free_q, done_q;
  logic [1:0]             req_func_q;
  logic [KeyW-1:0]        req_key_q;
  logic                   req_hid_q;
  logic [SizeW-1:0]       req_size_q;
  logic                   hit_hid_q;
  logic [SizeW-1:0]       hit_size_q;
  status_e                status_q, status_d;
  logic                   fhid_q, fhid_d;
  logic [SizeW-1:0]       fsize_q, fsize_d;
  logic                   issue, accept, res_d, ent_valid, ent_match;
  rec_t                   rd_data;
  wr_req_t                wr_req;
  logic [IDX_W-1:0]       wr_addr;

  kst_ram #(
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data),
    .wr_i      (wr_req),
    .wr_addr_i (wr_addr)
  );

  assign accept    = start && (state_q == FSM_IDLE);
  assign busy      = (state_q != FSM_IDLE);
  assign ent_valid = valid_q[chk_idx_q];
  assign ent_match = ent_valid && (rd_data.key == req_key_q);

  always_comb begin
    state_d          = state_q;
    issue            = 1'b0;
    res_d            = 1'b0;
    valid_d          = valid_q;
    count_d          = count_q;
    status_d         = status_q;
    fhid_d           = 1'b0;
    fsize_d          = '0;
    wr_req.en        = 1'b0;
    wr_req.data.key  = req_key_q;
    wr_req.data.hidden = req_hid_q;
    wr_req.data.size = req_size_q;
    wr_addr          = hit_idx_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (start) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        issue = !rd_end_q;
        if (chk_vld_q && (chk_idx_q == LastIdx)) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        state_d = FSM_IDLE;
        res_d   = 1'b1;
        case (req_func_q)
          FUNC_SET: begin
            if (hit_q) begin
              wr_req.en = 1'b1;
              status_d  = ST_UPDATED;
            end else if ((count_q >= MaxCnt) || !free_q) begin
              status_d = ST_FULL;
            end else begin
              wr_req.en           = 1'b1;
              wr_addr             = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
              count_d             = count_q + CNT_W'(1);
              status_d            = ST_INSERTED;
            end
          end
          FUNC_REMOVE: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            status_d = ST_REMOVED;
          end
          FUNC_FIND: begin
            if (hit_q) begin
              status_d = ST_FOUND;
              fhid_d   = hit_hid_q;
              fsize_d  = hit_size_q;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: status_d = ST_NOT_FOUND;
        endcase
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      valid_q   <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_end_q  <= 1'b0;
      chk_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      done_q    <= res_d;
      chk_vld_q <= issue;
      if (accept) begin
        rd_idx_q <= '0;
        rd_end_q <= 1'b0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        if (issue) begin
          if (rd_idx_q == LastIdx) begin
            rd_end_q <= 1'b1;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        if (chk_vld_q && ent_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (chk_vld_q && !ent_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx_q;
    if (accept) begin
      req_func_q <= func_i;
      req_key_q  <= slot_key_i;
      req_hid_q  <= hidden_flag_i;
      req_size_q <= image_bytes_i;
    end
    if (chk_vld_q && ent_match && !hit_q) begin
      hit_idx_q  <= chk_idx_q;
      hit_hid_q  <= rd_data.hidden;
      hit_size_q <= rd_data.size;
    end
    if (chk_vld_q && !ent_valid && !free_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (res_d) begin
      status_q <= status_d;
      fhid_q   <= fhid_d;
      fsize_q  <= fsize_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign found_hidden_o      = fhid_q;
  assign found_image_bytes_o = fsize_q;
  assign entry_count_o       = 4'(count_q);

  `KST_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held for two cycles")
  `KST_ASSERT(a_count_bound, count_q <= MaxCnt, "entry count above table size")
  `KST_ASSERT(a_count_match, $countones(valid_q) == int'(count_q), "count differs from valid bits")
  `KST_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "accepted request not in work")

endmodule

// ===== tb/sv/keyed_slot_table_tb.sv =====
// Self-checking testbench for keyed_slot_table: predicts each set, remove and find result.
module keyed_slot_table_tb;
  import kst_pkg::*;

  localparam int unsigned TableDepth = MaxEntriesDef;
  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam int          RandomReqs = 880;
  localparam int          MaxReports = 10;

  typedef struct {
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    logic             hid;
    logic [SizeW-1:0] bytes;
  } slot_req_t;

  typedef struct {
    status_e          st;
    logic             hid;
    logic [SizeW-1:0] bytes;
    logic [3:0]       count;
  } slot_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                func_i = FUNC_FIND;
  logic [KeyW-1:0]           slot_key_i = '0;
  logic                      hidden_flag_i = 1'b0;
  logic [SizeW-1:0]          image_bytes_i = '0;
  logic                      done_o;
  logic [2:0]                status_o;
  logic                      found_hidden_o;
  logic [SizeW-1:0]          found_image_bytes_o;
  logic [3:0]                entry_count_o;

  keyed_slot_table #(
    .MAX_ENTRIES(TableDepth)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .slot_key_i         (slot_key_i),
    .hidden_flag_i      (hidden_flag_i),
    .image_bytes_i      (image_bytes_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .found_hidden_o     (found_hidden_o),
    .found_image_bytes_o(found_image_bytes_o),
    .entry_count_o      (entry_count_o)
  );

  slot_req_t    request_q[$];
  slot_result_t pending_results_q[$];

  logic             tbl_valid [TableDepth];
  logic [KeyW-1:0]  tbl_key   [TableDepth];
  logic             tbl_hidden[TableDepth];
  logic [SizeW-1:0] tbl_size  [TableDepth];
  int unsigned      tbl_count;

  int total_reqs;
  int reqs_accepted;
  int results_seen;
  int fail_cnt;
  int status_seen[6];

  // Table predictor: update the shadow records and return the expected result.
  function automatic slot_result_t apply_table_op(slot_req_t req);
    slot_result_t res;
    int           hit;
    int           free;
    hit  = -1;
    free = -1;
    res.st    = ST_NOT_FOUND;
    res.hid   = 1'b0;
    res.bytes = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == req.key) hit = i;
      if (!tbl_valid[i]) free = i;
    end
    case (req.op)
      FUNC_SET: begin
        if (hit >= 0) begin
          tbl_hidden[hit] = req.hid;
          tbl_size[hit]   = req.bytes;
          res.st = ST_UPDATED;
        end else if (tbl_count >= TableDepth || free < 0) begin
          res.st = ST_FULL;
        end else begin
          tbl_valid[free]  = 1'b1;
          tbl_key[free]    = req.key;
          tbl_hidden[free] = req.hid;
          tbl_size[free]   = req.bytes;
          tbl_count++;
          res.st = ST_INSERTED;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end
        res.st = ST_REMOVED;
      end
      FUNC_FIND: begin
        if (hit >= 0) begin
          res.st    = ST_FOUND;
          res.hid   = tbl_hidden[hit];
          res.bytes = tbl_size[hit];
        end
      end
      default: res.st = ST_NOT_FOUND;
    endcase
    res.count = tbl_count[3:0];
    return res;
  endfunction

  task automatic queue_request(logic [1:0] op, logic [KeyW-1:0] key, logic hid,
                               logic [SizeW-1:0] bytes);
    slot_req_t req;
    req.op    = op;
    req.key   = key;
    req.hid   = hid;
    req.bytes = bytes;
    request_q.insert(request_q.size(), req);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // Driver: hold a request until accepted, then idle or advance.
  always @(posedge clk_i) begin : drive
    slot_req_t cur;
    logic      take;
    int        idle_pct;
    if (rst_ni) begin
      take = start && !busy;
      if (take) begin
        pending_results_q.insert(pending_results_q.size(), apply_table_op(cur));
        reqs_accepted++;
      end
      if (!start || take) begin
        if (reqs_accepted < total_reqs / 3) idle_pct = 37;
        else if (reqs_accepted < 2 * total_reqs / 3) idle_pct = 67;
        else idle_pct = 0;
        if (request_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          cur = request_q.pop_front();
          start         <= 1'b1;
          func_i        <= cur.op;
          slot_key_i    <= cur.key;
          hidden_flag_i <= cur.hid;
          image_bytes_i <= cur.bytes;
        end else begin
          start         <= 1'b0;
          func_i        <= 2'($urandom);
          slot_key_i    <= KeyW'($urandom);
          hidden_flag_i <= 1'($urandom);
          image_bytes_i <= $urandom;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk_i) begin : watch
    slot_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("unexpected result: status %0d count %0d", status_o, entry_count_o);
      end else begin
        want = pending_results_q.pop_front();
        if (status_o !== want.st || found_hidden_o !== want.hid ||
            found_image_bytes_o !== want.bytes || entry_count_o !== want.count) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("mismatch: status %0d/%0d hidden %0b/%0b bytes %h/%h count %0d/%0d",
                     want.st, status_o, want.hid, found_hidden_o, want.bytes,
                     found_image_bytes_o, want.count, entry_count_o);
        end
        if (int'(want.st) < 6) status_seen[int'(want.st)]++;
      end
    end
  end

  initial begin
    int               roll;
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] bytes;
    for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
    tbl_count     = 0;
    reqs_accepted = 0;
    results_seen  = 0;
    fail_cnt      = 0;

    queue_request(FUNC_FIND, 8'd0, 1'b1, 32'hFFFF_FFFF);
    queue_request(FUNC_REMOVE, 8'd255, 1'b0, 32'h0);
    queue_request(FUNC_SET, 8'd0, 1'b1, 32'hFFFF_FFFF);
    queue_request(FUNC_SET, 8'd255, 1'b0, 32'h0);
    queue_request(FUNC_FIND, 8'd0, 1'b0, 32'h0);
    queue_request(FUNC_SET, 8'd0, 1'b0, 32'h1234_5678);
    for (int k = 1; k <= TableDepth - 2; k++)
      queue_request(FUNC_SET, KeyW'(k), 1'($urandom), $urandom);
    queue_request(FUNC_SET, 8'd7, 1'b1, 32'hA5A5_A5A5);
    queue_request(FUNC_FIND, 8'd7, 1'b0, 32'h0);
    queue_request(FuncUnused, 8'd0, 1'b1, 32'hFFFF_FFFF);
    queue_request(FUNC_REMOVE, 8'd3, 1'b0, 32'h0);
    queue_request(FUNC_SET, 8'd7, 1'b1, 32'h8000_0001);
    queue_request(FUNC_FIND, 8'd255, 1'b1, 32'hFFFF_FFFF);
    queue_request(FUNC_REMOVE, 8'd0, 1'b0, 32'h0);
    queue_request(FUNC_FIND, 8'd0, 1'b0, 32'h0);
    queue_request(FuncUnused, 8'd255, 1'b0, 32'h0);

    // Keep most keys in a small pool so the table fills, hits and rejects.
    for (int n = 0; n < RandomReqs; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 45) op = FUNC_SET;
      else if (roll < 68) op = FUNC_REMOVE;
      else if (roll < 95) op = FUNC_FIND;
      else op = FuncUnused;
      if ($urandom_range(99, 0) < 80) key = KeyW'($urandom_range(11, 0));
      else key = KeyW'($urandom);
      roll = $urandom_range(9, 0);
      if (roll == 0) bytes = '0;
      else if (roll == 1) bytes = '1;
      else bytes = $urandom;
      queue_request(op, key, 1'($urandom), bytes);
    end
    total_reqs = request_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_accepted < total_reqs || pending_results_q.size() != 0) @(posedge clk_i);
    repeat (2 * (TableDepth + 3)) @(posedge clk_i);
    fail_cnt += pending_results_q.size();

    $display("%0d requests, %0d results checked, %0d failures", reqs_accepted,
             results_seen, fail_cnt);
    $display("updated %0d inserted %0d full %0d removed %0d found %0d not found %0d",
             status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_FULL],
             status_seen[ST_REMOVED], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND]);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_ram.sv
rtl/keyed_slot_table.sv
tb/sv/keyed_slot_table_tb.sv
